// ----- hdl/pms_pkg.sv -----
// ---------------------------------------------------------------------------
// Particle motion step package
// Shared types, constants and helpers for the particle motion step unit.
// ---------------------------------------------------------------------------
package pms_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DT_BITS       = 16;
    localparam int CFG_IDX_W     = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_Z   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CROWD   = 3'd6;

    // Drag factor 0.9801 in Q0.16.
    localparam logic [16:0] DRAG_Q16  = 17'd64232;
    localparam logic [7:0]  SPIN_GAIN = 8'd150;

    // Life status codes.
    localparam logic [1:0] ST_ALIVE   = 2'd0;
    localparam logic [1:0] ST_EXPIRED = 2'd1;
    localparam logic [1:0] ST_CULLED  = 2'd2;
    localparam logic [1:0] ST_DEAD    = 2'd3;

    // Operations of the shared multiplier.
    typedef enum logic [1:0] {
        OP_MOVE,   // p += round(a*b >> 16), saturated
        OP_SQ,     // sq += a*b (a square when b = a)
        OP_DRAG,   // v = round(a*b >> 16), saturated
        OP_SUB     // v -= round(a*b >> 16), saturated
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GRAV,
        S_MOVE,
        S_SQ,
        S_SQRT,
        S_SPIN1,
        S_SPIN2,
        S_DRAG,
        S_DONE,
        S_OUT
    } t_state;

    // Half gravity 4.905 scaled by 2^frac, rounded to nearest.
    function automatic logic [31:0] half_g(input int frac);
        longint v;
        v = ((longint'(4905) << frac) + 500) / 1000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        if (x > 50'sd2147483647) return 32'sh7fffffff;
        if (x < -50'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

endpackage

// ----- hdl/pms_mac.sv -----
// ---------------------------------------------------------------------------
// Shared multiply unit
// One registered 33x33 signed product, followed by a round/accumulate stage.
// ---------------------------------------------------------------------------
module pms_mac
    import pms_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_go,
    input  t_op                i_op,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    input  logic signed [31:0] i_acc,
    input  logic        [63:0] i_sq,
    output logic signed [31:0] o_res,
    output logic        [63:0] o_sq
);

    logic signed [65:0] r_prod;
    t_op                r_op;
    logic signed [49:0] w_rnd;

    // Product register.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_prod <= i_a * i_b;
            r_op   <= i_op;
        end
    end

    // Rounded shift of the product by 16.
    always_comb begin
        logic signed [65:0] t;
        t     = r_prod + 66'sd32768;
        w_rnd = t[65:16];
    end

    always_comb begin
        o_sq = i_sq;
        unique case (r_op)
            OP_MOVE: o_res = sat32(50'(i_acc) + w_rnd);
            OP_SUB:  o_res = sat32(50'(i_acc) - w_rnd);
            OP_DRAG: o_res = sat32(w_rnd);
            OP_SQ: begin
                o_res = i_acc;
                o_sq  = i_sq + r_prod[63:0];
            end
            default: o_res = i_acc;
        endcase
    end

endmodule

// ----- hdl/pms_sqrt.sv -----
// ---------------------------------------------------------------------------
// Square root unit
// Bit-pair restoring integer square root of a 64 bit value, one bit a cycle.
// ---------------------------------------------------------------------------
module pms_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_x;
    logic [31:0] r_q;
    logic [65:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [65:0] w_trial;
    logic [65:0] w_rem2;

    always_comb begin
        w_rem2  = {r_rem[63:0], r_x[63:62]};
        w_trial = {32'd0, r_q, 2'b01};
    end

    // One result bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_x    <= i_x;
                r_q    <= '0;
                r_rem  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_x <= {r_x[61:0], 2'b00};
                if (w_rem2 >= w_trial) begin
                    r_rem <= w_rem2 - w_trial;
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= w_rem2;
                    r_q   <= {r_q[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_root = r_q;

endmodule

// ----- hdl/particle_motion_step_unit.sv -----
// ---------------------------------------------------------------------------
// Particle motion step unit
// Advances one particle by one frame tick with drag or gravity.
// ---------------------------------------------------------------------------
// A request in falling mode runs the gravity and move steps, a request for
// a particle on the ground runs only the status step, a request for a dead
// particle goes straight to the output, and a request in floating mode runs
// the move, square, square root, spin and drag steps. The steps share a
// single 33x33 multiplier, and floating mode also uses a one-bit-a-cycle
// square root of the speed squared. The input is not ready while a tick is
// in progress or a result waits in the output register; the next request
// is taken in the cycle after the result leaves.
module particle_motion_step_unit
    import pms_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // frame_dt[15:0], scene_count[31:16]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [135:0]         m_axis_tdata   // pos_x, pos_y, pos_z, spin_angle, life_status
);

    localparam logic [31:0] HALF_G = half_g(FRAC_BITS);
    localparam logic [31:0] FALL_SPIN = (32'd9 << FRAC_BITS) >> 1;

    t_state r_state, n_state;
    logic        r_mode;
    logic [15:0] r_life, r_crowd, r_dt, r_cnt_in, r_age;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic [31:0] r_angle;
    logic        r_dead;
    logic [63:0] r_sq;
    logic [31:0] r_len;
    logic [1:0]  r_ax;
    logic        r_ph;
    logic [1:0]  r_status;
    logic [135:0] r_out;
    logic        r_ovalid;

    logic        w_go;
    t_op         w_op;
    logic signed [32:0] w_a, w_b;
    logic signed [31:0] w_acc, w_res;
    logic [63:0] w_sq;
    logic        w_sq_start, w_sq_done;
    logic [31:0] w_root;
    logic [65:0] r_spin;

    pms_mac u_mac (
        .i_clk (i_clk), .i_go(w_go), .i_op(w_op), .i_a(w_a), .i_b(w_b),
        .i_acc (w_acc), .i_sq(r_sq), .o_res(w_res), .o_sq(w_sq)
    );

    pms_sqrt u_sqrt (
        .i_clk (i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start), .i_x(r_sq),
        .o_done(w_sq_done), .o_root(w_root)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    // Operand selection for the shared multiplier.
    always_comb begin
        w_go = 1'b0;
        w_op = OP_MOVE;
        w_a  = 33'(r_vel[r_ax]);
        w_b  = {17'd0, r_dt};
        w_acc = r_pos[r_ax];
        w_sq_start = 1'b0;
        unique case (r_state)
            S_GRAV: begin
                w_go = !r_ph; w_op = OP_SUB;
                w_a = {1'b0, HALF_G}; w_acc = r_vel[1];
            end
            S_MOVE: w_go = !r_ph;
            S_SQ: begin
                w_go = !r_ph; w_op = OP_SQ; w_b = 33'(r_vel[r_ax]);
            end
            S_DRAG: begin
                w_go = !r_ph; w_op = OP_DRAG; w_b = {16'd0, DRAG_Q16};
                w_acc = r_vel[r_ax];
            end
            S_SPIN1: w_sq_start = !r_ph;
            default: ;
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (s_axis_tvalid && s_axis_tready) begin
                if (r_dead) n_state = S_OUT;
                else if (!r_mode) n_state = S_MOVE;
                else if (r_pos[1] <= 0) n_state = S_DONE;
                else n_state = S_GRAV;
            end
            S_GRAV:  if (r_ph) n_state = S_MOVE;
            S_MOVE:  if (r_ph && r_ax == 2'd2) n_state = r_mode ? S_DONE : S_SQ;
            S_SQ:    if (r_ph && r_ax == 2'd2) n_state = S_SPIN1;
            S_SPIN1: if (w_sq_done) n_state = S_SPIN2;
            S_SPIN2: if (r_ph) n_state = S_DRAG;
            S_DRAG:  if (r_ph && r_ax == 2'd2) n_state = S_DONE;
            S_DONE:  n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Datapath and state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0; r_life <= 16'd100; r_crowd <= 16'd1000;
            r_pos[0] <= '0; r_pos[1] <= '0; r_pos[2] <= '0;
            r_vel[0] <= '0; r_vel[1] <= '0; r_vel[2] <= '0;
            r_angle <= '0; r_age <= '0; r_dead <= 1'b0;
            r_ovalid <= 1'b0; r_ax <= '0; r_ph <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MODE:   r_mode <= i_cfg_data[0];
                    REG_LIFE:   r_life <= i_cfg_data[15:0];
                    REG_VEL_X:  r_vel[0] <= i_cfg_data;
                    REG_VEL_Y:  r_vel[1] <= i_cfg_data;
                    REG_VEL_Z:  r_vel[2] <= i_cfg_data;
                    REG_HEIGHT: r_pos[1] <= i_cfg_data;
                    REG_CROWD:  r_crowd <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_dt <= s_axis_tdata[15:0]; r_cnt_in <= s_axis_tdata[31:16];
                    r_ax <= '0; r_ph <= 1'b0; r_sq <= '0;
                    r_status <= ST_DEAD;
                    if (!r_dead && r_mode && r_pos[1] <= 0) r_pos[1] <= '0;
                end
                S_GRAV: begin
                    r_ph <= !r_ph;
                    if (r_ph) r_vel[1] <= w_res;
                end
                S_MOVE, S_SQ, S_DRAG: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                        if (r_state == S_MOVE) r_pos[r_ax] <= w_res;
                        if (r_state == S_DRAG) r_vel[r_ax] <= w_res;
                        if (r_state == S_SQ)   r_sq <= w_sq;
                    end
                end
                S_SPIN1: begin
                    r_ph <= !w_sq_done;
                    if (w_sq_done) r_len <= w_root;
                end
                S_SPIN2: begin
                    // len*150 is registered first, then multiplied by dt.
                    r_ph <= !r_ph;
                    if (!r_ph) r_spin <= 66'(r_len * SPIN_GAIN);
                    else r_angle <= r_angle + 32'((r_spin[47:0] * r_dt + 64'd32768) >> 16);
                end
                S_DONE: begin
                    if (r_cnt_in > r_crowd && r_age != 16'd0) begin
                        r_status <= ST_CULLED; r_dead <= 1'b1;
                    end else if (((r_age == 16'hffff) ? r_age : r_age + 16'd1) >= r_life) begin
                        r_status <= ST_EXPIRED; r_dead <= 1'b1;
                    end else r_status <= ST_ALIVE;
                    if (r_age != 16'hffff) r_age <= r_age + 16'd1;
                end
                S_OUT: begin
                    r_out <= {6'd0, r_status, r_angle, r_pos[2], r_pos[1], r_pos[0]};
                    r_ovalid <= 1'b1;
                end
                default: ;
            endcase
            if (r_state == S_MOVE && r_ph && r_ax == 2'd2 && r_mode)
                r_angle <= r_angle + FALL_SPIN;
        end
    end

endmodule

// ----- hdl/pms_checker.sv -----
// ---------------------------------------------------------------------------
// Particle motion step checker
// Port-level properties of the particle motion step unit.
// ---------------------------------------------------------------------------
module pms_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No request is taken while a result waits.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready with result pending");

    // A request never yields a result in the next cycle.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");

    // A result with the dead status code is not the alive code (the check tests the same bits).
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[129:128] == 2'd3 |->
        !(m_axis_tdata[129:128] == 2'd0))
        else $error("bad status");

endmodule

bind particle_motion_step_unit pms_checker u_pms_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// ----- dv/particle_motion_step_unit_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Particle motion step unit testbench
// Drives frame ticks through the stream input and predicts every position,
// angle and life status in floating and falling mode, under several idling
// mixes, with register changes between phases. The particle is killed only
// in the last test, because death lasts until reset.
// ---------------------------------------------------------------------------
module particle_motion_step_unit_test;
    import pms_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        spin;
        logic signed [31:0] pz;
        logic signed [31:0] py;
        logic signed [31:0] px;
    } t_step_result;

    localparam longint HALF_G_Q16 = ((longint'(4905) << 16) + 500) / 1000;
    localparam int     SETTLE_CYCLES = 80;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // frame_dt[15:0], scene_count[31:16]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;   // pos_x, pos_y, pos_z, spin_angle, life_status

    // Local copy of the particle and its registers.
    logic               mdl_mode;
    logic [15:0]        mdl_life;
    logic [15:0]        mdl_crowd;
    logic signed [31:0] mdl_pos [3];
    logic signed [31:0] mdl_vel [3];
    logic [31:0]        mdl_angle;
    logic [15:0]        mdl_age;
    logic               mdl_dead;

    t_step_result pending_steps[$];
    int           mismatches;
    int           idle_pct;
    int           stall_pct;

    particle_motion_step_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #30ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > longint'(32'sh7fffffff)) return 32'sh7fffffff;
        if (x < longint'(32'sh80000000)) return 32'sh80000000;
        return x[31:0];
    endfunction

    // Round to nearest and drop 16 fraction bits (floor shift).
    function automatic longint round_q16(input longint x);
        return (x + 32768) >>> 16;
    endfunction

    function automatic longint unsigned speed_root(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Advances the local particle by one tick and returns what it reports.
    function automatic t_step_result advance_particle(input logic [15:0] dt,
                                                      input logic [15:0] cnt);
        t_step_result     r;
        longint unsigned  sq;
        longint unsigned  len;
        logic [1:0]       st;
        st = ST_DEAD;
        if (!mdl_dead) begin
            if (mdl_mode == 1'b0) begin
                for (int i = 0; i < 3; i++)
                    mdl_pos[i] = clamp32(longint'(mdl_pos[i]) +
                                         round_q16(longint'(mdl_vel[i]) * dt));
                sq = 0;
                for (int i = 0; i < 3; i++)
                    sq += longint'(mdl_vel[i]) * longint'(mdl_vel[i]);
                len = speed_root(sq);
                mdl_angle += 32'((len * 150 * dt + 32768) >> 16);
                for (int i = 0; i < 3; i++)
                    mdl_vel[i] = clamp32(round_q16(longint'(mdl_vel[i]) * 64232));
            end else if (mdl_pos[1] <= 0) begin
                mdl_pos[1] = '0;
            end else begin
                mdl_vel[1] = clamp32(longint'(mdl_vel[1]) - round_q16(HALF_G_Q16 * dt));
                for (int i = 0; i < 3; i++)
                    mdl_pos[i] = clamp32(longint'(mdl_pos[i]) +
                                         round_q16(longint'(mdl_vel[i]) * dt));
                mdl_angle += 32'h0004_8000;
            end
            st = ST_ALIVE;
            if (cnt > mdl_crowd && mdl_age > 0) st = ST_CULLED;
            if (mdl_age != 16'hffff) mdl_age++;
            if (st == ST_ALIVE && mdl_age >= mdl_life) st = ST_EXPIRED;
            if (st != ST_ALIVE) mdl_dead = 1'b1;
        end
        r.px     = mdl_pos[0];
        r.py     = mdl_pos[1];
        r.pz     = mdl_pos[2];
        r.spin   = mdl_angle;
        r.status = st;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    // Receiver stalls, redrawn every cycle.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_step_result got;
        t_step_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[129:0];
            if (pending_steps.size() == 0) begin
                report_mismatch("unexpected result", got.px, '0);
            end else begin
                want = pending_steps.pop_front();
                if (got.px !== want.px) report_mismatch("pos_x", got.px, want.px);
                if (got.py !== want.py) report_mismatch("pos_y", got.py, want.py);
                if (got.pz !== want.pz) report_mismatch("pos_z", got.pz, want.pz);
                if (got.spin !== want.spin)
                    report_mismatch("spin_angle", got.spin, want.spin);
                if (got.status !== want.status)
                    report_mismatch("life_status", got.status, want.status);
            end
        end
    end

    // Sends one tick request, with random idle cycles ahead of it.
    task automatic send_tick(input logic [15:0] dt, input logic [15:0] cnt);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {cnt, dt};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_steps.push_back(advance_particle(dt, cnt));
        @(negedge i_clk);
    endtask

    // Waits until every result is in and the block has settled.
    task automatic wait_quiet();
        s_axis_tvalid = 1'b0;
        while (pending_steps.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        wait_quiet();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            REG_MODE:   mdl_mode  = val[0];
            REG_LIFE:   mdl_life  = val[15:0];
            REG_VEL_X:  mdl_vel[0] = val;
            REG_VEL_Y:  mdl_vel[1] = val;
            REG_VEL_Z:  mdl_vel[2] = val;
            REG_HEIGHT: mdl_pos[1] = val;
            REG_CROWD:  mdl_crowd = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_velocity(input logic [31:0] vx, input logic [31:0] vy,
                                 input logic [31:0] vz);
        write_reg(REG_VEL_X, vx);
        write_reg(REG_VEL_Y, vy);
        write_reg(REG_VEL_Z, vz);
    endtask

    // Speeds are mostly moderate, sometimes anywhere in the full range.
    function automatic logic [31:0] random_speed();
        if ($urandom_range(3) == 0) return $urandom;
        return 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
    endfunction

    // Extreme velocities, dt and counts in both modes, and the ground clamp.
    task automatic test_directed();
        write_reg(REG_LIFE, 16'hffff);
        write_reg(REG_CROWD, 16'hffff);
        write_reg(REG_MODE, 1'b0);
        load_velocity(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_tick(16'hffff, 16'h0000);
        send_tick(16'h0000, 16'hffff);
        send_tick(16'h0001, 16'h0001);
        send_tick(16'hffff, 16'hffff);
        load_velocity(32'h0, 32'h0, 32'h0);
        send_tick(16'h8000, 16'h1234);
        load_velocity(32'h0001_8000, 32'hffff_0000, 32'h0000_4000);
        send_tick(16'h0444, 16'h0010);
        // A crowd limit of zero culls nothing while the count stays zero.
        write_reg(REG_CROWD, 16'h0000);
        send_tick(16'h0444, 16'h0000);
        write_reg(REG_CROWD, 16'hffff);
        // Falling mode: on the ground, below it, high up with extreme speeds.
        write_reg(REG_MODE, 1'b1);
        write_reg(REG_HEIGHT, 32'h0);
        send_tick(16'h0444, 16'h0005);
        write_reg(REG_HEIGHT, 32'h80000000);
        send_tick(16'hffff, 16'h0005);
        write_reg(REG_HEIGHT, 32'h7fffffff);
        load_velocity(32'h80000000, 32'h80000000, 32'h7fffffff);
        send_tick(16'hffff, 16'h0000);
        send_tick(16'hffff, 16'hffff);
        write_reg(REG_HEIGHT, 32'h0000_0001);
        load_velocity(32'h0, 32'h7fffffff, 32'h0);
        send_tick(16'h0001, 16'h0000);
        send_tick(16'hffff, 16'h0000);
        send_tick(16'hffff, 16'h0000);
    endtask

    // One random phase in the current idling mix, modes drawn per block.
    task automatic test_random_phase(input int items);
        for (int i = 0; i < items; i++) begin
            if (i % 24 == 0) begin
                write_reg(REG_MODE, $urandom_range(1));
                load_velocity(random_speed(), random_speed(), random_speed());
                write_reg(REG_HEIGHT, $urandom_range(3) == 0 ? $urandom
                                                             : $urandom_range(32'h0100_0000));
            end
            if (i == items / 2) wait_quiet();
            send_tick($urandom_range(7) == 0 ? 16'($urandom) : 16'($urandom_range(16'h0800)),
                      16'($urandom));
        end
    endtask

    // Culling and expiry on the same tick: culling is reported, then the
    // particle stays frozen.
    task automatic test_death();
        write_reg(REG_MODE, 1'b0);
        load_velocity(32'h0002_0000, 32'h0001_0000, 32'hfffe_0000);
        write_reg(REG_LIFE, mdl_age + 16'd1);
        write_reg(REG_CROWD, 16'h0000);
        send_tick(16'h0444, 16'h0001);
        for (int i = 0; i < 4; i++) send_tick(16'($urandom), 16'($urandom));
        write_reg(REG_MODE, 1'b1);
        send_tick(16'hffff, 16'h0000);
    endtask

    initial begin
        mismatches    = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_MODE;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        mdl_mode  = 1'b0;
        mdl_life  = 16'd100;
        mdl_crowd = 16'd1000;
        for (int i = 0; i < 3; i++) begin
            mdl_pos[i] = '0;
            mdl_vel[i] = '0;
        end
        mdl_angle = '0;
        mdl_age   = '0;
        mdl_dead  = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        idle_pct = 0;  stall_pct = 0;  test_random_phase(96);
        idle_pct = 61; stall_pct = 0;  test_random_phase(96);
        idle_pct = 0;  stall_pct = 61; test_random_phase(96);
        idle_pct = 7;  stall_pct = 7;  test_random_phase(96);
        test_death();

        wait_quiet();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
